// ----- rtl/core/urd_pkg.sv -----
// Shared widths for the unique random draw core.
// Used by the modulo unit and the top level; depends on nothing.
`default_nettype none

package urd_pkg;

  localparam int WORD_W  = 32;
  localparam int START_W = 16;
  localparam int SIZE_W  = 9;
  localparam int VALUE_W = 17;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  typedef enum logic [0:0] {
    CFG_RANGE_START = 1'b0,
    CFG_RANGE_SIZE  = 1'b1
  } cfg_index_t;

endpackage

`default_nettype wire

// ----- rtl/core/urd_mod.sv -----
// Bit-serial restoring modulo unit: one dividend bit per cycle.
// Depends on urd_pkg for the dividend width.
`default_nettype none

module urd_mod #(
  parameter int CW = 9
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [urd_pkg::WORD_W-1:0] dividend,
  input  wire logic [CW-1:0]             divisor,
  output logic                           done,
  output logic [CW-1:0]                  rem
);

  localparam int CNT_W = $clog2(urd_pkg::WORD_W);

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [urd_pkg::WORD_W-1:0] word_sh;
  logic [CW-1:0]              dsr;
  logic [CW:0]                trial;
  logic [CW:0]                dsr_x;
  logic [CW-1:0]              rem_next;

  always_comb begin
    trial = {rem, word_sh[urd_pkg::WORD_W-1]};
    dsr_x = {1'b0, dsr};
    if (trial >= dsr_x) begin
      rem_next = CW'(trial - dsr_x);
    end else begin
      rem_next = CW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(urd_pkg::WORD_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      word_sh <= dividend;
      dsr     <= divisor;
      rem     <= '0;
    end else if (busy) begin
      word_sh <= {word_sh[urd_pkg::WORD_W-2:0], 1'b0};
      rem     <= rem_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/urd_map.sv -----
// Used map storage: one bit per entry, one write and one registered read port.
// Standalone; no package dependency.
`default_nettype none

module urd_map #(
  parameter int ENTRIES = 256,
  parameter int IW      = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic          re,
  input  wire logic [IW-1:0] raddr,
  output logic               rdata
);

  logic mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/unique_random_draw_core.sv -----
// Sequence: accept, serial modulo, then a sweep of all ENTRIES map entries (new set) or a
//   scan of the map up to the effective range size, then a load of the output register.
// Flow: one transaction at a time; in_ready stays low until the result is loaded into
//   the output register, and an already exhausted set skips the modulo and map steps.
// Reset: synchronous; a clearing pass writes every map entry while
//   in_ready is low. Configuration writes are taken at all times.
`default_nettype none

module unique_random_draw_core #(
  parameter int ENTRIES = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [0:0]                          cfg_index,
  input  wire logic [urd_pkg::START_W-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                new_set,
  input  wire logic [urd_pkg::WORD_W-1:0]          random_word,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [urd_pkg::VALUE_W-1:0]       drawn_value,
  output logic                                     exhausted
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_DIVIDE = 6'b000100,
    ST_SWEEP  = 6'b001000,
    ST_SCAN   = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state;

  logic signed [urd_pkg::START_W-1:0] range_start;
  logic [urd_pkg::SIZE_W-1:0]         range_size;
  logic [CW-1:0]                      eff_size;
  logic [CW-1:0]                      unused_count;
  logic [CW-1:0]                      unused_count_next;
  logic [CW-1:0]                      divisor;
  logic                               set_flag;
  logic [CW-1:0]                      rank;
  logic [IW-1:0]                      sweep_addr;
  logic [CW-1:0]                      rd_addr;
  logic                               chk_valid;
  logic [IW-1:0]                      chk_idx;
  logic [IW-1:0]                      sel_idx;
  logic                               res_exh;

  logic          mod_start;
  logic          mod_done;
  logic [CW-1:0] mod_rem;

  logic          map_we;
  logic [IW-1:0] map_waddr;
  logic          map_wdata;
  logic          map_re;
  logic          map_rdata;
  logic          found;
  logic          sweep_last;
  logic          accept;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state == ST_IDLE);
  assign sweep_last = (sweep_addr == IW'(ENTRIES - 1));
  assign found      = (state == ST_SCAN) && chk_valid && !map_rdata && (rank == '0);
  assign map_re     = (state == ST_SCAN) && (rd_addr < eff_size);

  always_comb begin
    if (range_size == '0) begin
      eff_size = CW'(1);
    end else if (32'(range_size) > 32'(ENTRIES)) begin
      eff_size = CW'(ENTRIES);
    end else begin
      eff_size = CW'(range_size);
    end
  end

  always_comb begin
    unused_count_next = new_set ? eff_size : unused_count;
    divisor           = unused_count_next;
    mod_start         = accept && (unused_count_next != '0);
  end

  always_comb begin
    map_we    = 1'b0;
    map_waddr = sweep_addr;
    map_wdata = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        map_we = 1'b1;
      end
      ST_SWEEP: begin
        map_we    = 1'b1;
        map_wdata = (sweep_addr == rank[IW-1:0]);
      end
      ST_SCAN: begin
        map_we    = found;
        map_waddr = chk_idx;
        map_wdata = 1'b1;
      end
      default: begin
        map_we = 1'b0;
      end
    endcase
  end

  urd_mod #(
    .CW(CW)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (random_word),
    .divisor  (divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  urd_map #(
    .ENTRIES(ENTRIES),
    .IW     (IW)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (rd_addr[IW-1:0]),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      range_start <= '0;
      range_size  <= urd_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        urd_pkg::CFG_RANGE_START: range_start <= cfg_data;
        urd_pkg::CFG_RANGE_SIZE:  range_size  <= cfg_data[urd_pkg::SIZE_W-1:0];
        default:                  range_size  <= range_size;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      sweep_addr   <= '0;
      unused_count <= CW'(ENTRIES < 256 ? ENTRIES : 256);
      out_valid    <= 1'b0;
      chk_valid    <= 1'b0;
      rd_addr      <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (sweep_last) begin
            sweep_addr <= '0;
            state      <= ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            unused_count <= unused_count_next;
            set_flag     <= new_set;
            sweep_addr   <= '0;
            rd_addr      <= '0;
            chk_valid    <= 1'b0;
            if (unused_count_next == '0) begin
              res_exh <= 1'b1;
              state   <= ST_EMIT;
            end else begin
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          if (mod_done) begin
            rank  <= mod_rem;
            state <= set_flag ? ST_SWEEP : ST_SCAN;
          end
        end
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + 1'b1;
          if (sweep_last) begin
            sel_idx      <= rank[IW-1:0];
            res_exh      <= 1'b0;
            unused_count <= unused_count - 1'b1;
            state        <= ST_EMIT;
          end
        end
        ST_SCAN: begin
          chk_valid <= map_re;
          chk_idx   <= rd_addr[IW-1:0];
          if (map_re) begin
            rd_addr <= rd_addr + 1'b1;
          end
          if (found) begin
            sel_idx      <= chk_idx;
            res_exh      <= 1'b0;
            unused_count <= unused_count - 1'b1;
            state        <= ST_EMIT;
          end else if (chk_valid && !map_rdata) begin
            rank <= rank - 1'b1;
          end else if (!chk_valid && !map_re) begin
            res_exh <= 1'b1;
            state   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            exhausted <= res_exh;
            if (res_exh) begin
              drawn_value <= '0;
            end else begin
              drawn_value <= urd_pkg::VALUE_W'(range_start)
                             + urd_pkg::VALUE_W'(sel_idx);
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    unused_count <= CW'(ENTRIES))
    else $error("unused count above map size");

  a_exh_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && exhausted |-> drawn_value == '0)
    else $error("exhausted result carries a value");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("ready held after accepting a transaction");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> state == ST_DIVIDE)
    else $error("modulo unit finished outside divide state");
`endif

endmodule

`default_nettype wire

// ----- verif/urd_draw_checker.sv -----
`timescale 1ns / 100ps
// Checker for unique_random_draw_core: follows register writes, predicts each draw
// and compares every result, in order, with the oldest prediction. Depends on urd_pkg.

module urd_draw_checker #(
  parameter int ENTRIES = 256
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [0:0]                         cfg_index,
  input  wire logic [urd_pkg::START_W-1:0]        cfg_data,
  input  wire logic                               in_valid,
  input  wire logic                               in_ready,
  input  wire logic                               new_set,
  input  wire logic [urd_pkg::WORD_W-1:0]         random_word,
  input  wire logic                               out_valid,
  input  wire logic                               out_ready,
  input  wire logic signed [urd_pkg::VALUE_W-1:0] drawn_value,
  input  wire logic                               exhausted,
  output int                                      mismatches,
  output int                                      outstanding
);

  typedef struct packed {
    logic [urd_pkg::VALUE_W-1:0] value;
    logic                        exhausted;
  } draw_t;

  logic [ENTRIES-1:0]          taken_map;
  int unsigned                 free_count;
  logic [urd_pkg::START_W-1:0] cur_start;
  logic [urd_pkg::SIZE_W-1:0]  cur_size;
  draw_t                       expected_draws[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic int unsigned range_span();
    int unsigned s;
    s = 32'(cur_size);
    if (s == 0) s = 1;
    if (s > ENTRIES) s = ENTRIES;
    return s;
  endfunction

  function automatic draw_t predict_draw(logic fresh, logic [urd_pkg::WORD_W-1:0] word);
    int unsigned size;
    int unsigned rank;
    draw_t       r;
    size = range_span();
    if (fresh) begin
      taken_map = '0;
      free_count = size;
    end
    r.value = '0;
    r.exhausted = 1'b1;
    if (free_count == 0) return r;
    rank = word % free_count;
    for (int j = 0; j < size; j++) begin
      if (!taken_map[j]) begin
        if (rank == 0) begin
          taken_map[j] = 1'b1;
          free_count--;
          r.value = {cur_start[urd_pkg::START_W-1], cur_start} + urd_pkg::VALUE_W'(j);
          r.exhausted = 1'b0;
          return r;
        end
        rank--;
      end
    end
    return r;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    draw_t want;
    if (rst) begin
      cur_start = '0;
      cur_size = urd_pkg::SIZE_RESET;
      taken_map = '0;
      free_count = range_span();
      expected_draws.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == urd_pkg::CFG_RANGE_START) cur_start = cfg_data;
        else cur_size = cfg_data[urd_pkg::SIZE_W-1:0];
      end
      if (out_valid && out_ready) begin
        if (expected_draws.size() == 0) begin
          report("result transaction with no draw pending");
        end else begin
          want = expected_draws.pop_front();
          if (drawn_value !== want.value)
            report($sformatf("drawn_value %0d, expected %0d",
                             drawn_value, $signed(want.value)));
          if (exhausted !== want.exhausted)
            report($sformatf("exhausted %b, expected %b", exhausted, want.exhausted));
        end
      end
      if (in_valid && in_ready) expected_draws.push_back(predict_draw(new_set, random_word));
      outstanding <= expected_draws.size();
    end
  end

endmodule

// ----- verif/tb_unique_random_draw_core.sv -----
`timescale 1ns / 100ps
// Testbench top for unique_random_draw_core: clock, reset, range writes, draw
// stimulus, result back-pressure and verdict. Depends on urd_pkg and urd_draw_checker.

module tb_unique_random_draw_core;

  localparam int ENTRIES      = 256;
  localparam int RANDOM_DRAWS = 500;
  localparam int IDLE_LIMIT   = 8000;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 2000;

  logic                               clk;
  logic                               rst;
  logic                               cfg_we;
  logic [0:0]                         cfg_index;
  logic [urd_pkg::START_W-1:0]        cfg_data;
  logic                               in_valid;
  logic                               in_ready;
  logic                               new_set;
  logic [urd_pkg::WORD_W-1:0]         random_word;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [urd_pkg::VALUE_W-1:0] drawn_value;
  logic                               exhausted;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int random_draws = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  unique_random_draw_core #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .new_set    (new_set),
    .random_word(random_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drawn_value(drawn_value),
    .exhausted  (exhausted)
  );

  urd_draw_checker #(
    .ENTRIES(ENTRIES)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .new_set    (new_set),
    .random_word(random_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .drawn_value(drawn_value),
    .exhausted  (exhausted),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  // hold off once for a long stretch so the core fills up and stalls its input
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= no_idle || $urandom_range(0, 99) >= 19;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("unique_random_draw_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_draw(input logic fresh, input logic [urd_pkg::WORD_W-1:0] word);
    if (!no_idle && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 19);
    end
    in_valid <= 1'b1;
    new_set <= fresh;
    random_word <= word;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every predicted draw has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic write_range(input logic [urd_pkg::START_W-1:0] start,
                             input logic [urd_pkg::START_W-1:0] size_word);
    cfg_we <= 1'b1;
    cfg_index <= urd_pkg::CFG_RANGE_START;
    cfg_data <= start;
    @(posedge clk);
    cfg_index <= urd_pkg::CFG_RANGE_SIZE;
    cfg_data <= size_word;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [urd_pkg::START_W-1:0] start;
    int                          size_raw;
    int                          set_span;
    int                          draws_left;
    bit                          keep_set;
    logic [urd_pkg::WORD_W-1:0]  word;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= urd_pkg::CFG_RANGE_START;
    cfg_data <= '0;
    in_valid <= 1'b0;
    new_set <= 1'b0;
    random_word <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset range, no new set yet
    send_draw(1'b0, '0);
    send_draw(1'b0, '1);
    send_draw(1'b1, 32'd12345);
    drain();
    // single-value range at the top start, then exhaustion
    write_range(16'h7FFF, 16'd1);
    send_draw(1'b1, '1);
    send_draw(1'b0, '0);
    send_draw(1'b0, '1);
    send_draw(1'b1, '0);
    drain();
    // size zero acts as one
    write_range(16'h8000, 16'd0);
    send_draw(1'b1, 32'd7);
    send_draw(1'b0, 32'd3);
    drain();
    // size above the map acts as the full map
    write_range(16'h8000, 16'd511);
    send_draw(1'b1, '1);
    send_draw(1'b0, '0);
    drain();
    // shrink the range within a set
    write_range(16'hFFFB, 16'd8);
    send_draw(1'b1, '0);
    send_draw(1'b0, '0);
    drain();
    write_range(16'hFFFB, 16'd3);
    send_draw(1'b0, '0);
    send_draw(1'b0, 32'd4);
    send_draw(1'b0, '0);
    drain();
    // highest value
    write_range(16'h7FFF, 16'd256);
    send_draw(1'b1, '1);

    while (random_draws < RANDOM_DRAWS) begin
      drain();
      case ($urandom_range(0, 5))
        0: start = 16'h8000;
        1: start = 16'h7FFF;
        default: start = urd_pkg::START_W'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0: size_raw = 0;
        1: size_raw = 1;
        2: size_raw = 256;
        3: size_raw = $urandom_range(257, 511);
        4: size_raw = $urandom_range(17, 255);
        default: size_raw = $urandom_range(2, 16);
      endcase
      set_span = size_raw == 0 ? 1 : (size_raw > ENTRIES ? ENTRIES : size_raw);
      keep_set = $urandom_range(0, 4) == 0;
      write_range(start, {7'($urandom), 9'(size_raw)});
      draws_left = set_span + $urandom_range(0, 3);
      if (set_span > 16) draws_left = $urandom_range(4, 24);
      for (int i = 0; i < draws_left; i++) begin
        no_idle <= random_draws >= 200 && random_draws < 300;
        if (random_draws == 100) hold_req <= 1'b1;
        word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * set_span) : $urandom;
        send_draw(i == 0 ? !keep_set : $urandom_range(0, 19) == 0, word);
        random_draws++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("unique_random_draw_core test passed");
    end else begin
      $display("unique_random_draw_core test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/urd_pkg.sv
rtl/core/urd_mod.sv
rtl/core/urd_map.sv
rtl/core/unique_random_draw_core.sv
verif/urd_draw_checker.sv
verif/tb_unique_random_draw_core.sv
